/* rtl/lphm_pkg.sv */
// Types and constants shared by the linear probing hash map.
`default_nettype none
package lphm_pkg;

   localparam int unsigned KEY_W    = 32;
   localparam int unsigned VALUE_W  = 31;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned SIZE_W   = 4;
   localparam int unsigned MIN_SIZE_LOG2 = 6;
   localparam logic [KEY_W-1:0] HASH_MULT = 32'd73856093;
   localparam logic [SIZE_W-1:0] SIZE_LOG2_RESET = 4'd10;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
   localparam logic [STATUS_W-1:0] ST_DROPPED  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_HIT      = 2'd2;
   localparam logic [STATUS_W-1:0] ST_MISS     = 2'd3;

   typedef struct packed {
      logic               command;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [VALUE_W-1:0]  found_value;
   } rsp_type;

   typedef struct packed {
      logic               used;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
   } entry_type;

endpackage
`default_nettype wire

/* rtl/linear_probe_hash_map.sv */
// Open-addressing hash table with linear probing, one probe memory and a sequencer.
//
// After reset the block sweeps the slot memory once, one slot per cycle, with
// req_stall high; csr writes are taken during the sweep. Each item is then
// accepted in S_IDLE and hashed by the multiply in S_HASH; for each slot
// probed the address goes to the slot memory in S_READ and the registered
// read is checked in S_CHECK, which holds the result while the output register
// is full and stalled. The result waits in an output register while the next
// item is accepted. csr_data holds size_log2: values below 6 act as 6, above
// MAX_SIZE_LOG2 as MAX_SIZE_LOG2. Write it only while the block is idle.
`default_nettype none
module linear_probe_hash_map #(
   parameter int unsigned MAX_SIZE_LOG2 = 10
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_valid,
   output logic                        req_stall,
   input  lphm_pkg::req_type           req_data,
   output logic                        rsp_valid,
   input  wire                         rsp_stall,
   output lphm_pkg::rsp_type           rsp_data,
   input  wire                         csr_valid,
   output logic                        csr_ready,
   input  wire [lphm_pkg::SIZE_W-1:0]  csr_data
);

   localparam int unsigned DEPTH = 1 << MAX_SIZE_LOG2;

   typedef enum logic [4:0] {
      S_CLEAR = 5'b00001,
      S_IDLE  = 5'b00010,
      S_HASH  = 5'b00100,
      S_READ  = 5'b01000,
      S_CHECK = 5'b10000
   } state_type;

   state_type                           state_ff, state_in;
   logic [MAX_SIZE_LOG2-1:0]            clr_ff, clr_in;
   logic [lphm_pkg::SIZE_W-1:0]         size_log2_ff, size_log2_in;
   logic                                cmd_ff, cmd_in;
   logic [lphm_pkg::KEY_W-1:0]          key_ff, key_in;
   logic [lphm_pkg::VALUE_W-1:0]        value_ff, value_in;
   logic [lphm_pkg::KEY_W-1:0]          prod_ff, prod_in;
   logic [MAX_SIZE_LOG2-1:0]            pos_ff, pos_in;
   logic [MAX_SIZE_LOG2-1:0]            n_ff, n_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   lphm_pkg::rsp_type                   rsp_ff, rsp_in;

   lphm_pkg::entry_type                 mem [DEPTH];
   lphm_pkg::entry_type                 rdata_ff;
   lphm_pkg::entry_type                 wr_data;
   logic [MAX_SIZE_LOG2-1:0]            wr_addr;
   logic                                wr_en;

   logic [MAX_SIZE_LOG2-1:0]            mask;
   logic                                out_free;
   logic                                last_probe;
   logic                                done;
   lphm_pkg::rsp_type                   result;

   always_comb begin
      for (int i = 0; i < MAX_SIZE_LOG2; i++) begin
         mask[i] = (i < lphm_pkg::MIN_SIZE_LOG2) || (i < int'(size_log2_ff));
      end
   end

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign last_probe = (n_ff == mask);
   assign req_stall  = (state_ff != S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   always_comb begin
      done              = 1'b0;
      result.status     = lphm_pkg::ST_MISS;
      result.found_value = '0;
      if (cmd_ff == lphm_pkg::CMD_INSERT) begin
         if (!rdata_ff.used) begin
            done          = 1'b1;
            result.status = lphm_pkg::ST_INSERTED;
         end else if (last_probe) begin
            done          = 1'b1;
            result.status = lphm_pkg::ST_DROPPED;
         end
      end else begin
         if (!rdata_ff.used) begin
            done = 1'b1;
         end else if (rdata_ff.key == key_ff) begin
            done               = 1'b1;
            result.status      = lphm_pkg::ST_HIT;
            result.found_value = rdata_ff.value;
         end else if (last_probe) begin
            done = 1'b1;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      size_log2_in = size_log2_ff;
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      value_in     = value_ff;
      prod_in      = prod_ff;
      pos_in       = pos_ff;
      n_in         = n_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = pos_ff;
      wr_data.used  = 1'b1;
      wr_data.key   = key_ff;
      wr_data.value = value_ff;

      if (csr_valid && csr_ready) begin
         size_log2_in = csr_data;
      end
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_CLEAR: begin
            wr_en        = 1'b1;
            wr_addr      = clr_ff;
            wr_data.used = 1'b0;
            clr_in       = clr_ff + 1'b1;
            if (clr_ff == {MAX_SIZE_LOG2{1'b1}}) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd_in   = req_data.command;
               key_in   = req_data.key;
               value_in = req_data.value;
               state_in = S_HASH;
            end
         end
         S_HASH: begin
            prod_in  = key_ff * lphm_pkg::HASH_MULT;
            state_in = S_READ;
         end
         S_READ: begin
            if (n_ff == '0) begin
               pos_in = prod_ff[MAX_SIZE_LOG2-1:0] & mask;
            end
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (done) begin
               if (out_free) begin
                  wr_en        = (cmd_ff == lphm_pkg::CMD_INSERT) && !rdata_ff.used;
                  rsp_valid_in = 1'b1;
                  rsp_in       = result;
                  n_in         = '0;
                  state_in     = S_IDLE;
               end
            end else begin
               pos_in   = (pos_ff + 1'b1) & mask;
               n_in     = n_ff + 1'b1;
               state_in = S_READ;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Home slot is set in S_READ on the first probe; the read uses pos_in then.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rdata_ff <= mem[pos_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         size_log2_ff <= lphm_pkg::SIZE_LOG2_RESET;
         n_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         size_log2_ff <= size_log2_in;
         n_ff         <= n_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      key_ff   <= key_in;
      value_ff <= value_in;
      prod_ff  <= prod_in;
      pos_ff   <= pos_in;
      rsp_ff   <= rsp_in;
   end

   a_accept_to_hash: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == S_HASH))
      else $error("accepted request did not start the hash");

   a_rsp_from_check: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == S_CHECK))
      else $error("response raised outside the check step");

   a_zero_on_no_hit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status != lphm_pkg::ST_HIT)) |-> (rsp_data.found_value == '0))
      else $error("found_value nonzero without a hit");

   a_stall_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> (req_stall && !wr_data.used))
      else $error("request taken or slot marked used during the clear sweep");

endmodule
`default_nettype wire

/* verif/tb_linear_probe_hash_map.sv */
// Testbench for linear_probe_hash_map: insert and lookup beats checked against a table model.
`timescale 1ns / 1ps
module tb_linear_probe_hash_map;

   localparam int unsigned MAX_LOG2 = 10;
   localparam int unsigned SLOTS_MAX = 1 << MAX_LOG2;
   localparam longint unsigned CYCLE_LIMIT = 20_000_000;
   localparam int unsigned DRAIN_CYCLES = 16;
   localparam int unsigned REPORT_MAX = 10;
   localparam int unsigned HOLD_CYCLES = 400;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   lphm_pkg::req_type             req_data;
   logic                          rsp_valid;
   logic                          rsp_stall;
   lphm_pkg::rsp_type             rsp_data;
   logic                          csr_valid;
   logic                          csr_ready;
   logic [lphm_pkg::SIZE_W-1:0]   csr_data;

   logic [lphm_pkg::KEY_W-1:0]    tbl_key [SLOTS_MAX];
   logic [lphm_pkg::VALUE_W-1:0]  tbl_value [SLOTS_MAX];
   bit                            tbl_used [SLOTS_MAX];
   logic [lphm_pkg::SIZE_W-1:0]   tbl_size_log2;

   lphm_pkg::rsp_type             predicted_rsps[$];
   logic [lphm_pkg::KEY_W-1:0]    stored_keys[$];
   logic [lphm_pkg::KEY_W-1:0]    wrap_key;

   int unsigned         send_idle_pct;
   int unsigned         stall_pct;
   int unsigned         hold_left;
   int unsigned         mismatches = 0;
   longint unsigned     cycle_count = 0;

   linear_probe_hash_map #(
      .MAX_SIZE_LOG2(MAX_LOG2)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int unsigned active_log2();
      int unsigned lg;
      lg = 32'(tbl_size_log2);
      if (lg < lphm_pkg::MIN_SIZE_LOG2) lg = lphm_pkg::MIN_SIZE_LOG2;
      if (lg > MAX_LOG2) lg = MAX_LOG2;
      return lg;
   endfunction

   function automatic int unsigned home_slot(logic [lphm_pkg::KEY_W-1:0] key,
                                             int unsigned lg);
      logic [lphm_pkg::KEY_W-1:0] h;
      h = key * lphm_pkg::HASH_MULT;
      return h & ((1 << lg) - 1);
   endfunction

   function automatic logic [lphm_pkg::KEY_W-1:0] key_for_slot(int unsigned slot,
                                                               int unsigned lg);
      logic [lphm_pkg::KEY_W-1:0] k;
      k = 1;
      while (home_slot(k, lg) != slot) k++;
      return k;
   endfunction

   function automatic logic [lphm_pkg::VALUE_W-1:0] rand_value();
      logic [31:0] r;
      r = $urandom();
      return r[lphm_pkg::VALUE_W-1:0];
   endfunction

   function automatic lphm_pkg::rsp_type probe_table(lphm_pkg::req_type r);
      int unsigned lg;
      int unsigned slots;
      int unsigned mask;
      int unsigned pos;
      int unsigned s;
      lphm_pkg::rsp_type res;
      lg = active_log2();
      slots = 1 << lg;
      mask = slots - 1;
      pos = home_slot(r.key, lg);
      res.status = (r.command == lphm_pkg::CMD_INSERT) ? lphm_pkg::ST_DROPPED
                                                        : lphm_pkg::ST_MISS;
      res.found_value = '0;
      for (int unsigned n = 0; n < slots; n++) begin
         s = (pos + n) & mask;
         if (r.command == lphm_pkg::CMD_INSERT) begin
            if (!tbl_used[s]) begin
               tbl_used[s] = 1'b1;
               tbl_key[s] = r.key;
               tbl_value[s] = r.value;
               res.status = lphm_pkg::ST_INSERTED;
               break;
            end
         end else begin
            if (!tbl_used[s]) break;
            if (tbl_key[s] == r.key) begin
               res.status = lphm_pkg::ST_HIT;
               res.found_value = tbl_value[s];
               break;
            end
         end
      end
      return res;
   endfunction

   task automatic send_op(input logic cmd, input logic [lphm_pkg::KEY_W-1:0] key,
                          input logic [lphm_pkg::VALUE_W-1:0] value);
      lphm_pkg::req_type r;
      r.command = cmd;
      r.key = key;
      r.value = value;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_data = r;
      req_valid = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted_rsps.push_back(probe_table(r));
      if (cmd == lphm_pkg::CMD_INSERT) stored_keys.push_back(key);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (predicted_rsps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_size(input logic [lphm_pkg::SIZE_W-1:0] size_log2);
      wait_drained();
      @(negedge clock);
      csr_valid = 1'b1;
      csr_data = size_log2;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      tbl_size_log2 = size_log2;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic logic [lphm_pkg::KEY_W-1:0] pick_stored_key();
      return stored_keys[$urandom_range(stored_keys.size() - 1)];
   endfunction

   task automatic test_directed();
      send_idle_pct = 0;
      stall_pct = 0;
      send_op(lphm_pkg::CMD_LOOKUP, 32'h0000_0000, 31'h7FFF_FFFF);
      send_op(lphm_pkg::CMD_INSERT, 32'h0000_0000, 31'h7FFF_FFFF);
      send_op(lphm_pkg::CMD_INSERT, 32'hFFFF_FFFF, 31'h0000_0000);
      send_op(lphm_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 31'h0000_0000);
      send_op(lphm_pkg::CMD_LOOKUP, 32'h0000_0000, 31'h0000_0000);
      send_op(lphm_pkg::CMD_INSERT, 32'h0000_0000, 31'h2AAA_AAAA);
      send_op(lphm_pkg::CMD_LOOKUP, 32'h0000_0000, 31'h5555_5555);
      // chain that starts at the last slot and wraps past the entries at slots zero and one
      wrap_key = key_for_slot(SLOTS_MAX - 1, MAX_LOG2);
      send_op(lphm_pkg::CMD_INSERT, wrap_key, 31'h1234_5678);
      send_op(lphm_pkg::CMD_INSERT, wrap_key + SLOTS_MAX, 31'h0765_4321);
      send_op(lphm_pkg::CMD_INSERT, wrap_key + 2 * SLOTS_MAX, 31'h7F00_00FF);
      send_op(lphm_pkg::CMD_LOOKUP, wrap_key + 2 * SLOTS_MAX, 31'h0);
      send_op(lphm_pkg::CMD_LOOKUP, wrap_key + 3 * SLOTS_MAX, 31'h0);
      send_op(lphm_pkg::CMD_LOOKUP, wrap_key + SLOTS_MAX, 31'h7FFF_FFFF);
      send_op(lphm_pkg::CMD_LOOKUP, wrap_key, 31'h0);
      send_op(lphm_pkg::CMD_INSERT, 32'hA5A5_5A5A, 31'h5A5A_A5A5);
      send_op(lphm_pkg::CMD_LOOKUP, 32'hA5A5_5A5A, 31'h0);
      send_op(lphm_pkg::CMD_LOOKUP, $urandom(), rand_value());
   endtask

   task automatic test_table_full();
      write_size(4'd0);
      send_idle_pct = 10;
      stall_pct = 10;
      send_op(lphm_pkg::CMD_LOOKUP, wrap_key, 31'h0);
      repeat (SLOTS_MAX >> (MAX_LOG2 - lphm_pkg::MIN_SIZE_LOG2))
         send_op(lphm_pkg::CMD_INSERT, $urandom(), rand_value());
      send_op(lphm_pkg::CMD_INSERT, $urandom(), rand_value());
      send_op(lphm_pkg::CMD_INSERT, $urandom(), rand_value());
      send_op(lphm_pkg::CMD_LOOKUP, $urandom(), rand_value());
      send_op(lphm_pkg::CMD_LOOKUP, stored_keys[stored_keys.size() - 10], 31'h0);
      repeat (8) send_op(lphm_pkg::CMD_LOOKUP, pick_stored_key(), rand_value());
   endtask

   task automatic test_random_mix(input logic [lphm_pkg::SIZE_W-1:0] size_log2,
                                  input int unsigned count,
                                  input int unsigned insert_pct, input int unsigned idle_pct,
                                  input int unsigned hold_pct, input int unsigned pause_at,
                                  input int unsigned hold_at);
      logic [lphm_pkg::KEY_W-1:0] key;
      logic cmd;
      int unsigned roll;
      write_size(size_log2);
      send_idle_pct = idle_pct;
      stall_pct = hold_pct;
      for (int unsigned i = 0; i < count; i++) begin
         if (i == pause_at) wait_drained();
         if (i == hold_at) hold_left = HOLD_CYCLES;
         cmd = ($urandom_range(99) < insert_pct) ? lphm_pkg::CMD_INSERT
                                                 : lphm_pkg::CMD_LOOKUP;
         roll = $urandom_range(99);
         if (cmd == lphm_pkg::CMD_INSERT) begin
            if (roll < 20) key = pick_stored_key() + ($urandom_range(1, 7) << MAX_LOG2);
            else if (roll < 30) key = pick_stored_key();
            else key = $urandom();
         end else begin
            if (roll < 65) key = pick_stored_key();
            else if (roll < 80) key = pick_stored_key() + ($urandom_range(1, 7) << MAX_LOG2);
            else key = $urandom();
         end
         send_op(cmd, key, rand_value());
      end
   endtask

   always @(negedge clock) begin
      if (hold_left != 0) begin
         rsp_stall = 1'b1;
         hold_left = hold_left - 1;
      end else begin
         rsp_stall = ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin : check_rsp
      lphm_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (predicted_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("unexpected result beat: status %0d found_value %h",
                        rsp_data.status, rsp_data.found_value);
         end else begin
            want = predicted_rsps.pop_front();
            if (rsp_data.status !== want.status ||
                rsp_data.found_value !== want.found_value) begin
               mismatches++;
               if (mismatches <= REPORT_MAX)
                  $display("result mismatch: expected status %0d found_value %h, got %0d %h",
                           want.status, want.found_value,
                           rsp_data.status, rsp_data.found_value);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_linear_probe_hash_map: FAIL");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      hold_left = 0;
      send_idle_pct = 0;
      stall_pct = 0;
      tbl_size_log2 = lphm_pkg::SIZE_LOG2_RESET;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_table_full();
      test_random_mix(4'd8, 600, 30, 32, 59, 600, 100);
      test_random_mix(4'd15, 700, 30, 59, 32, 350, 700);
      test_random_mix(4'd9, 600, 20, 0, 0, 600, 600);
      wait_drained();

      if (mismatches == 0 && predicted_rsps.size() == 0)
         $display("tb_linear_probe_hash_map: PASS");
      else
         $display("tb_linear_probe_hash_map: FAIL");
      $finish;
   end

endmodule
